// ===== rtl/emhq_pkg.sv =====
// Shared types and constants for the edge min-heap queue.
package emhq_pkg;

  localparam int CAPACITY  = 256;
  localparam int NODE_BITS = 8;
  localparam int ADDR_W    = $clog2(CAPACITY);
  localparam int CNT_W     = $clog2(CAPACITY + 1);

  localparam logic MODE_PUSH = 1'b0;
  localparam logic MODE_POP  = 1'b1;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic signed [31:0]     weight;
    logic [NODE_BITS-1:0]   from;
    logic [NODE_BITS-1:0]   to;
  } entry_t;

endpackage

// ===== rtl/edge_min_heap_queue_unit.sv =====
// Top level of the edge min-heap queue: sequencer, shared comparator, result registers.
//
// Usage
//   A request is taken on a rising edge with start high and busy low.
//   mode 0 pushes the edge (weight, edge_from, edge_to); mode 1 pops the
//   minimum-weight edge. Each request gives one result, shown for exactly
//   one cycle with done high; the receiver cannot stall it.
//   status: ok, pop on an empty heap, or push on a full heap (heap untouched).
//   out_* carry the popped edge, zero otherwise; heap_empty and entry_count
//   give the fill after the request.
// Timing
//   Rejected requests: result in the cycle after acceptance, busy never rises.
//   Push: per level climbed, a parent read (S_UP_RD), then a compare (S_UP_CMP).
//   Pop: root and last entry are taken (S_POP_LAST, S_POP_TAKE), then per level
//   descended two child reads and two compares (S_DN_CHK, S_DN_L, S_DN_C, S_DN_S).
//   Reads use the single read port (data registered); compares use the one shared
//   32-bit signed comparator. busy is high while a push or pop is in progress; a new
//   request may be taken in the cycle done is shown.
// Reset
//   rst (synchronous) empties the heap; storage contents are not cleared.
module edge_min_heap_queue_unit (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  logic                 mode,
  input  logic signed [31:0]   weight,
  input  logic [7:0]           edge_from,
  input  logic [7:0]           edge_to,
  output logic                 done,
  output logic [1:0]           status,
  output logic signed [31:0]   out_weight,
  output logic [7:0]           out_from,
  output logic [7:0]           out_to,
  output logic                 heap_empty,
  output logic [8:0]           entry_count
);

  localparam int AW = emhq_pkg::ADDR_W;
  localparam int CW = emhq_pkg::CNT_W;

  // sequencer codes
  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_UP_RD    = 4'd1;
  localparam logic [3:0] S_UP_CMP   = 4'd2;
  localparam logic [3:0] S_POP_LAST = 4'd3;
  localparam logic [3:0] S_POP_TAKE = 4'd4;
  localparam logic [3:0] S_DN_CHK   = 4'd5;
  localparam logic [3:0] S_DN_L     = 4'd6;
  localparam logic [3:0] S_DN_C     = 4'd7;
  localparam logic [3:0] S_DN_S     = 4'd8;

  logic [3:0] state, state_next;
  logic [CW-1:0] count, count_next;
  logic [AW-1:0] pos, pos_next;
  emhq_pkg::entry_t hold, hold_next;     // entry being sifted; its slot is the hole
  emhq_pkg::entry_t child, child_next;   // smaller child on the way down
  logic child_r, child_r_next;
  logic done_next;
  logic [1:0] res_status, res_status_next;
  emhq_pkg::entry_t res, res_next;

  // storage port
  logic               we;
  logic [AW-1:0]      wr_addr, rd_addr;
  emhq_pkg::entry_t   wr_data, rd_data;

  emhq_store u_store (
    .clk     (clk),
    .we      (we),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // index arithmetic
  logic [AW-1:0] parent;
  logic [AW+1:0] kid_l, kid_r, cnt_x;
  assign parent = AW'((pos - AW'(1)) >> 1);
  assign kid_l  = {1'b0, pos, 1'b1};
  assign kid_r  = kid_l + (AW+2)'(1);
  assign cnt_x  = (AW+2)'(count);

  // the shared comparator: cmp_a > cmp_b, signed
  logic signed [31:0] cmp_a, cmp_b;
  logic gt;
  assign gt = cmp_a > cmp_b;

  always_comb begin
    unique case (state)
      S_UP_CMP: begin cmp_a = rd_data.weight; cmp_b = hold.weight;    end
      S_DN_C:   begin cmp_a = child.weight;   cmp_b = rd_data.weight; end
      default:  begin cmp_a = hold.weight;    cmp_b = child.weight;   end
    endcase
  end

  emhq_pkg::entry_t in_entry;
  assign in_entry.weight = weight;
  assign in_entry.from   = edge_from[emhq_pkg::NODE_BITS-1:0];
  assign in_entry.to     = edge_to[emhq_pkg::NODE_BITS-1:0];

  always_comb begin
    state_next      = state;
    count_next      = count;
    pos_next        = pos;
    hold_next       = hold;
    child_next      = child;
    child_r_next    = child_r;
    done_next       = 1'b0;
    res_status_next = res_status;
    res_next        = res;
    we              = 1'b0;
    wr_addr         = pos;
    wr_data         = hold;
    rd_addr         = '0;

    unique case (state)
      S_IDLE: begin
        rd_addr = '0;                       // root, for a pop
        if (start) begin
          res_next        = '0;
          res_status_next = emhq_pkg::ST_OK;
          if (mode == emhq_pkg::MODE_PUSH) begin
            if (count >= CW'(emhq_pkg::CAPACITY)) begin
              res_status_next = emhq_pkg::ST_FULL;
              done_next       = 1'b1;
            end else begin
              hold_next  = in_entry;
              pos_next   = count[AW-1:0];
              count_next = count + CW'(1);
              state_next = S_UP_RD;
            end
          end else begin
            if (count == '0) begin
              res_status_next = emhq_pkg::ST_EMPTY;
              done_next       = 1'b1;
            end else begin
              state_next = S_POP_LAST;
            end
          end
        end
      end

      S_UP_RD: begin
        rd_addr = parent;
        if (pos == '0) begin
          we         = 1'b1;
          done_next  = 1'b1;
          state_next = S_IDLE;
        end else begin
          state_next = S_UP_CMP;
        end
      end

      S_UP_CMP: begin
        we = 1'b1;
        if (gt) begin
          wr_data    = rd_data;             // parent moves down into the hole
          pos_next   = parent;
          state_next = S_UP_RD;
        end else begin
          done_next  = 1'b1;
          state_next = S_IDLE;
        end
      end

      S_POP_LAST: begin
        rd_addr    = AW'(count - CW'(1));
        res_next   = rd_data;               // root
        state_next = S_POP_TAKE;
      end

      S_POP_TAKE: begin
        hold_next  = rd_data;               // last entry goes to the root
        count_next = count - CW'(1);
        pos_next   = '0;
        if (count == CW'(1)) begin
          done_next  = 1'b1;
          state_next = S_IDLE;
        end else begin
          state_next = S_DN_CHK;
        end
      end

      S_DN_CHK: begin
        rd_addr = kid_l[AW-1:0];
        if (kid_l >= cnt_x) begin
          we         = 1'b1;
          done_next  = 1'b1;
          state_next = S_IDLE;
        end else begin
          state_next = S_DN_L;
        end
      end

      S_DN_L: begin
        rd_addr      = kid_r[AW-1:0];
        child_next   = rd_data;
        child_r_next = 1'b0;
        state_next   = S_DN_C;
      end

      S_DN_C: begin
        if (kid_r < cnt_x && gt) begin
          child_next   = rd_data;
          child_r_next = 1'b1;
        end
        state_next = S_DN_S;
      end

      S_DN_S: begin
        we = 1'b1;
        if (gt) begin
          wr_data    = child;               // child moves up into the hole
          pos_next   = child_r ? kid_r[AW-1:0] : kid_l[AW-1:0];
          state_next = S_DN_CHK;
        end else begin
          done_next  = 1'b1;
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      done  <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    pos        <= pos_next;
    hold       <= hold_next;
    child      <= child_next;
    child_r    <= child_r_next;
    res_status <= res_status_next;
    res        <= res_next;
  end

  assign busy        = (state != S_IDLE);
  assign status      = res_status;
  assign out_weight  = res.weight;
  assign out_from    = 8'(res.from);
  assign out_to      = 8'(res.to);
  assign heap_empty  = (count == '0);
  assign entry_count = 9'(count);

endmodule

// ===== rtl/emhq_store.sv =====
// Heap entry storage: one write port, one read port with registered data.
module emhq_store (
  input  logic                       clk,
  input  logic                       we,
  input  logic [emhq_pkg::ADDR_W-1:0] wr_addr,
  input  emhq_pkg::entry_t           wr_data,
  input  logic [emhq_pkg::ADDR_W-1:0] rd_addr,
  output emhq_pkg::entry_t           rd_data
);

  emhq_pkg::entry_t mem [emhq_pkg::CAPACITY];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== test/tb_top.sv =====
// Self-checking testbench for edge_min_heap_queue_unit: heap predictor, scoreboard, driver.
module tb_top;

  // Run limit in clock cycles, with a wide margin over the slowest correct run of
  // about 1900 requests, each with its sift and any idle gap.
  localparam int CYCLE_LIMIT = 500_000;
  // Longest sift (a pop through seven levels) plus some slack.
  localparam int DRAIN_CYCLES = 48;

  // One result as the block should show it.
  typedef struct {
    logic [1:0]                  status;
    logic signed [31:0]          weight;
    logic [7:0]                  from;
    logic [7:0]                  to;
    logic                        empty;
    logic [emhq_pkg::CNT_W-1:0]  count;
  } heap_result_t;

  // Scoreboard: keeps its own copy of the heap, predicts the result of each
  // accepted request and compares what the block shows with the oldest
  // prediction still waiting.
  class heap_scoreboard;
    emhq_pkg::entry_t heap [emhq_pkg::CAPACITY];
    int               fill;
    heap_result_t     awaited [$];
    int               failures;

    function new();
      fill = 0;
      failures = 0;
    endfunction

    function int fill_level();
      return fill;
    endfunction

    function int outstanding();
      return awaited.size();
    endfunction

    // Climb from pos while the parent is strictly heavier; ties stay put.
    function void sift_up(int pos);
      int                 up;
      emhq_pkg::entry_t   tmp;
      logic signed [31:0] wu;
      logic signed [31:0] wp;
      while (pos > 0) begin
        up = (pos - 1) / 2;
        wu = heap[up].weight;
        wp = heap[pos].weight;
        if (!(wu > wp)) break;
        tmp = heap[up];
        heap[up] = heap[pos];
        heap[pos] = tmp;
        pos = up;
      end
    endfunction

    // Descend from the root; right child only when strictly lighter than left,
    // stop once the parent is no heavier than the chosen child.
    function void sift_down();
      int                 pos;
      int                 kid;
      emhq_pkg::entry_t   tmp;
      logic signed [31:0] wl;
      logic signed [31:0] wr;
      logic signed [31:0] wp;
      pos = 0;
      kid = 1;
      while (kid < fill) begin
        if (kid + 1 < fill) begin
          wl = heap[kid].weight;
          wr = heap[kid + 1].weight;
          if (wl > wr) kid = kid + 1;
        end
        wp = heap[pos].weight;
        wl = heap[kid].weight;
        if (!(wp > wl)) break;
        tmp = heap[pos];
        heap[pos] = heap[kid];
        heap[kid] = tmp;
        pos = kid;
        kid = 2 * pos + 1;
      end
    endfunction

    function void note_request(logic m, logic signed [31:0] w, logic [7:0] f,
                               logic [7:0] t);
      heap_result_t r;
      r.status = emhq_pkg::ST_OK;
      r.weight = '0;
      r.from = '0;
      r.to = '0;
      if (m == emhq_pkg::MODE_PUSH) begin
        if (fill >= emhq_pkg::CAPACITY) begin
          r.status = emhq_pkg::ST_FULL;
        end else begin
          heap[fill].weight = w;
          heap[fill].from = f;
          heap[fill].to = t;
          fill = fill + 1;
          sift_up(fill - 1);
        end
      end else begin
        if (fill == 0) begin
          r.status = emhq_pkg::ST_EMPTY;
        end else begin
          r.weight = heap[0].weight;
          r.from = heap[0].from;
          r.to = heap[0].to;
          fill = fill - 1;
          if (fill > 0) begin
            heap[0] = heap[fill];
            sift_down();
          end
        end
      end
      r.empty = (fill == 0);
      r.count = fill[emhq_pkg::CNT_W-1:0];
      awaited.push_back(r);
    endfunction

    function void check_result(heap_result_t got);
      heap_result_t exp_r;
      if (awaited.size() == 0) begin
        $error("result with no request outstanding: status %0d", got.status);
        failures++;
        return;
      end
      exp_r = awaited.pop_front();
      if (got.status !== exp_r.status) begin
        $error("status: expected %0d, got %0d", exp_r.status, got.status);
        failures++;
      end
      if (got.weight !== exp_r.weight) begin
        $error("out_weight: expected %0d, got %0d", exp_r.weight, got.weight);
        failures++;
      end
      if (got.from !== exp_r.from) begin
        $error("out_from: expected %0d, got %0d", exp_r.from, got.from);
        failures++;
      end
      if (got.to !== exp_r.to) begin
        $error("out_to: expected %0d, got %0d", exp_r.to, got.to);
        failures++;
      end
      if (got.empty !== exp_r.empty) begin
        $error("heap_empty: expected %0d, got %0d", exp_r.empty, got.empty);
        failures++;
      end
      if (got.count !== exp_r.count) begin
        $error("entry_count: expected %0d, got %0d", exp_r.count, got.count);
        failures++;
      end
    endfunction
  endclass

  // Block signals; every input has a known value from time zero.
  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               start = 1'b0;
  logic               mode = emhq_pkg::MODE_PUSH;
  logic signed [31:0] weight = '0;
  logic [7:0]         edge_from = '0;
  logic [7:0]         edge_to = '0;
  logic               busy;
  logic               done;
  logic [1:0]         status;
  logic signed [31:0] out_weight;
  logic [7:0]         out_from;
  logic [7:0]         out_to;
  logic               heap_empty;
  logic [8:0]         entry_count;

  heap_scoreboard sb = new();
  int             cycles = 0;

  edge_min_heap_queue_unit dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .mode(mode),
    .weight(weight),
    .edge_from(edge_from),
    .edge_to(edge_to),
    .done(done),
    .status(status),
    .out_weight(out_weight),
    .out_from(out_from),
    .out_to(out_to),
    .heap_empty(heap_empty),
    .entry_count(entry_count)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Result monitor. done is a one-cycle strobe that cannot be held off, so
  // every edge with done high carries exactly one result.
  always @(posedge clk) begin
    heap_result_t got;
    if (!rst && done) begin
      got.status = status;
      got.weight = out_weight;
      got.from = out_from;
      got.to = out_to;
      got.empty = heap_empty;
      got.count = entry_count;
      sb.check_result(got);
    end
  end

  // Watchdog: a hung handshake or a lost result ends the run here.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // Weight picker: full range, a narrow band so that equal keys meet in the tree,
  // a +-1000 band, and the signed extremes or values near them now and then.
  function automatic logic signed [31:0] pick_weight();
    logic signed [31:0] w;
    case ($urandom_range(0, 9)) inside
      [0:3]:   w = $urandom;
      [4:6]:   w = $signed($urandom_range(0, 16)) - 8;
      7:       w = $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
      8:       w = $urandom_range(0, 1) ? 32'sh7FFF_FFFF - $urandom_range(0, 3)
                                        : 32'sh8000_0000 + $urandom_range(0, 3);
      default: w = $signed($urandom_range(0, 2000)) - 1000;
    endcase
    return w;
  endfunction

  function automatic logic [7:0] pick_node();
    return 8'($urandom_range(0, 255));
  endfunction

  // Issue one request and hold it until accepted (start high, busy low at an
  // edge). Called at a rising edge. With gaps enabled the sender may then go
  // quiet for a burst, scribbling on the payload ports meanwhile.
  task automatic send_request(logic m, logic signed [31:0] w, logic [7:0] f,
                              logic [7:0] t, bit gaps);
    start <= 1'b1;
    mode <= m;
    weight <= w;
    edge_from <= f;
    edge_to <= t;
    do @(posedge clk); while (busy);
    sb.note_request(m, w, f, t);
    if (gaps && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      mode <= 1'($urandom_range(0, 1));
      weight <= $urandom;
      edge_from <= pick_node();
      edge_to <= pick_node();
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
  endtask

  task automatic push_edge(logic signed [31:0] w, logic [7:0] f, logic [7:0] t,
                           bit gaps);
    send_request(emhq_pkg::MODE_PUSH, w, f, t, gaps);
  endtask

  // Pops carry junk in the edge fields; the block must ignore them.
  task automatic pop_edge(bit gaps);
    send_request(emhq_pkg::MODE_POP, $urandom, pick_node(), pick_node(), gaps);
  endtask

  task automatic random_request(int push_pct, bit gaps);
    if ($urandom_range(0, 99) < push_pct)
      push_edge(pick_weight(), pick_node(), pick_node(), gaps);
    else
      pop_edge(gaps);
  endtask

  // Hold the sender off until every outstanding request has produced its
  // result. Polled on the falling edge to stay clear of the monitor.
  task automatic wait_all_results();
    start <= 1'b0;
    while (sb.outstanding() != 0) @(negedge clk);
    @(posedge clk);
  endtask

  initial begin
    bit gaps;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: pop on an empty heap, signed extremes, endpoint extremes,
    // equal keys, drain past empty.
    pop_edge(1'b0);
    push_edge(32'sh7FFF_FFFF, 8'hFF, 8'hFF, 1'b0);
    push_edge(32'sh8000_0000, 8'h00, 8'h00, 1'b0);
    push_edge(32'sh0000_0000, 8'hAA, 8'h55, 1'b0);
    push_edge(-32'sd1, 8'h55, 8'hAA, 1'b0);
    push_edge(32'sd5, 8'd1, 8'd2, 1'b0);
    push_edge(32'sd5, 8'd3, 8'd4, 1'b0);
    push_edge(32'sd5, 8'd5, 8'd6, 1'b0);
    push_edge(32'sh8000_0000, 8'd7, 8'd8, 1'b0);
    push_edge(32'sh7FFF_FFFF, 8'd9, 8'd10, 1'b0);
    repeat (10) pop_edge(1'b0);
    push_edge(32'sd1, 8'h0F, 8'hF0, 1'b0);
    pop_edge(1'b0);

    // Random mix around a shallow heap; idling switched on and off in chunks
    // so that gaps land on every phase of a sift.
    for (int chunk = 0; chunk < 5; chunk++) begin
      gaps = (chunk % 2 == 0);
      repeat (100) random_request(55, gaps);
    end

    // Let the heap settle completely before the fill run.
    wait_all_results();

    // Fill to capacity, bounce off the full heap, then drain past empty.
    while (sb.fill_level() < emhq_pkg::CAPACITY) random_request(88, 1'b1);
    repeat (8) push_edge(pick_weight(), pick_node(), pick_node(), 1'b1);
    while (sb.fill_level() > 0) random_request(12, 1'b1);
    repeat (4) pop_edge(1'b1);

    // Final stretch back to back, no idling.
    repeat (700) random_request(60, 1'b0);

    wait_all_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.failures == 0 && sb.outstanding() == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule
